// ===== design/xml_text_escaper_unit_macros.svh =====
// Assertion macros for the XML text escaper unit
`ifndef XML_TEXT_ESCAPER_UNIT_MACROS_SVH
`define XML_TEXT_ESCAPER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define XTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xte check failed");

// next-cycle implication, disabled during reset
`define XTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xte check failed");

`endif

// ===== design/xte_pkg.sv =====
// Shared types and character constants for the XML text escaper
`timescale 1ns / 1ps
package xte_pkg;

    localparam int RUN_MAX = 6;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_len;
    typedef logic [2:0] t_idx;

    typedef struct packed {
        t_byte [RUN_MAX-1:0] bytes;
        t_len                len;
    } t_run;

    typedef struct packed {
        logic hold_valid;
        t_idx idx;
    } t_status;

    localparam t_byte C_AMP   = 8'h26;
    localparam t_byte C_LT    = 8'h3C;
    localparam t_byte C_GT    = 8'h3E;
    localparam t_byte C_QUOT  = 8'h22;
    localparam t_byte C_HASH  = 8'h23;
    localparam t_byte C_SEMI  = 8'h3B;
    localparam t_byte C_SLASH = 8'h2F;
    localparam t_byte C_ZERO  = 8'h30;
    localparam t_byte C_A     = 8'h61;
    localparam t_byte C_B     = 8'h62;
    localparam t_byte C_L     = 8'h6C;
    localparam t_byte C_M     = 8'h6D;
    localparam t_byte C_O     = 8'h6F;
    localparam t_byte C_P     = 8'h70;
    localparam t_byte C_Q     = 8'h71;
    localparam t_byte C_R     = 8'h72;
    localparam t_byte C_T     = 8'h74;
    localparam t_byte C_U     = 8'h75;

    localparam t_byte CODE_SKIP_A  = 8'h81;
    localparam t_byte CODE_SKIP_B  = 8'h82;
    localparam t_byte CODE_BOLD_ON = 8'h86;
    localparam t_byte CODE_BOLD_OFF = 8'h87;
    localparam t_byte CODE_NEWLINE = 8'h8A;
    localparam t_byte PRINT_LOW    = 8'h20;
    localparam t_byte HIGH_LOW     = 8'h80;

endpackage

// ===== design/xte_decode.sv =====
// Expansion of one input byte into its escaped run of output bytes
`timescale 1ns / 1ps
module xte_decode (
    input  xte_pkg::t_byte i_byte,
    input  logic           i_cc,
    output xte_pkg::t_run  o_run
);
    import xte_pkg::*;

    // three ASCII decimal digits, hundreds first
    function automatic t_byte [2:0] dec_digits(input t_byte b);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  u;
        t_byte [2:0] d;
        h    = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
        r    = 7'(b - 8'(h) * 8'd100);
        prod = 15'(r) * 15'd205;
        t    = prod[14:11];
        u    = 4'(r - 7'(t) * 7'd10);
        d[2] = C_ZERO + t_byte'(h);
        d[1] = C_ZERO + t_byte'(t);
        d[0] = C_ZERO + t_byte'(u);
        return d;
    endfunction

    t_byte [2:0] w_dig;

    always_comb begin
        w_dig = dec_digits(i_byte);
        o_run = '0;
        unique case (i_byte)
            C_AMP: begin
                o_run.bytes[0] = C_AMP;
                o_run.bytes[1] = C_A;
                o_run.bytes[2] = C_M;
                o_run.bytes[3] = C_P;
                o_run.bytes[4] = C_SEMI;
                o_run.len      = 3'd5;
            end
            C_LT: begin
                o_run.bytes[0] = C_AMP;
                o_run.bytes[1] = C_L;
                o_run.bytes[2] = C_T;
                o_run.bytes[3] = C_SEMI;
                o_run.len      = 3'd4;
            end
            C_QUOT: begin
                o_run.bytes[0] = C_AMP;
                o_run.bytes[1] = C_Q;
                o_run.bytes[2] = C_U;
                o_run.bytes[3] = C_O;
                o_run.bytes[4] = C_T;
                o_run.bytes[5] = C_SEMI;
                o_run.len      = 3'd6;
            end
            CODE_SKIP_A, CODE_SKIP_B: begin
                o_run.len = 3'd0;
            end
            CODE_BOLD_ON: begin
                if (i_cc) begin
                    o_run.bytes[0] = C_LT;
                    o_run.bytes[1] = C_B;
                    o_run.bytes[2] = C_GT;
                    o_run.len      = 3'd3;
                end
            end
            CODE_BOLD_OFF: begin
                if (i_cc) begin
                    o_run.bytes[0] = C_LT;
                    o_run.bytes[1] = C_SLASH;
                    o_run.bytes[2] = C_B;
                    o_run.bytes[3] = C_GT;
                    o_run.len      = 3'd4;
                end
            end
            CODE_NEWLINE: begin
                if (i_cc) begin
                    o_run.bytes[0] = C_LT;
                    o_run.bytes[1] = C_B;
                    o_run.bytes[2] = C_R;
                    o_run.bytes[3] = C_SLASH;
                    o_run.bytes[4] = C_GT;
                    o_run.len      = 3'd5;
                end
            end
            default: begin
                if (i_byte < PRINT_LOW) begin
                    o_run.len = 3'd0;
                end else if (i_byte < HIGH_LOW) begin
                    o_run.bytes[0] = i_byte;
                    o_run.len      = 3'd1;
                end else begin
                    o_run.bytes[0] = C_AMP;
                    o_run.bytes[1] = C_HASH;
                    o_run.bytes[2] = w_dig[2];
                    o_run.bytes[3] = w_dig[1];
                    o_run.bytes[4] = w_dig[0];
                    o_run.bytes[5] = C_SEMI;
                    o_run.len      = 3'd6;
                end
            end
        endcase
    end

endmodule

// ===== design/xte_seq.sv =====
// Input holding register, run index and output register
`timescale 1ns / 1ps
module xte_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cc,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  xte_pkg::t_byte   i_in_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output xte_pkg::t_byte   o_out_byte,
    output logic             o_last_of_run,
    output xte_pkg::t_status o_status
);
    import xte_pkg::*;

    logic  r_hold_valid, n_hold_valid;
    t_byte r_hold_byte;
    t_idx  r_idx, n_idx;
    logic  r_out_valid, n_out_valid;
    t_byte r_out_byte;
    logic  r_out_last;

    t_run  w_run;
    logic  w_out_free;
    logic  w_empty;
    logic  w_at_end;
    logic  w_emit;
    logic  w_done;
    logic  w_accept;

    xte_decode u_decode (
        .i_byte (r_hold_byte),
        .i_cc   (i_cc),
        .o_run  (w_run)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_empty    = (w_run.len == 3'd0);
    assign w_at_end   = (r_idx == 3'(w_run.len - 3'd1));
    assign w_emit     = r_hold_valid && !w_empty && w_out_free;
    assign w_done     = r_hold_valid && (w_empty || (w_emit && w_at_end));
    assign o_in_ready = !r_hold_valid || w_done;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_idx        = r_idx;
        if (w_accept) begin
            n_hold_valid = 1'b1;
            n_idx        = '0;
        end else if (w_done) begin
            n_hold_valid = 1'b0;
            n_idx        = '0;
        end else if (w_emit) begin
            n_idx = r_idx + 3'd1;
        end
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold_byte <= i_in_byte;
        end
        if (w_emit) begin
            r_out_byte <= w_run.bytes[r_idx];
            r_out_last <= w_at_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_status      = '{hold_valid: r_hold_valid, idx: r_idx};

endmodule

// ===== design/xml_text_escaper_unit.sv =====
// Top level of the XML text escaper unit
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) takes one text byte per
//   transfer. Output channel (o_out_valid / i_out_ready) delivers the escaped
//   text one byte per transfer; o_last_of_run marks the final byte of the run
//   belonging to one input byte. Dropped bytes give no output at all.
//   Config channel (i_cfg_valid / o_cfg_ready) writes control_codes_enable;
//   it is always ready and should only be written while the unit is idle.
//   An accepted input byte is registered in the holding register; its run
//   is decoded from it and stepped into the output register. Throughput: one
//   output byte per cycle while i_out_ready does not stall it; runs are 1 to
//   6 bytes long, stepped by the run index into the single output register.
//   The next input byte is taken in the cycle the last byte of the current
//   run moves into the output register.
//   Stall: while i_out_ready is low the output register holds its byte and
//   the run index waits; the held input byte stays until its run is done.
//   Reset (synchronous, active low) empties both registers and clears
//   control_codes_enable.
`timescale 1ns / 1ps
`include "xml_text_escaper_unit_macros.svh"
module xml_text_escaper_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_control_codes_enable,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  xte_pkg::t_byte i_in_byte,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output xte_pkg::t_byte o_out_byte,
    output logic           o_last_of_run
);
    import xte_pkg::*;

    logic    r_cc;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cc <= i_cfg_control_codes_enable;
        end
    end

    xte_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cc          (r_cc),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_status      (w_status)
    );

    `XTE_ASSERT_NOW(a_idle_idx_zero, i_clk, i_rst_n, !w_status.hold_valid, w_status.idx == 3'd0)
    `XTE_ASSERT_NOW(a_idx_in_run, i_clk, i_rst_n, w_status.hold_valid, w_status.idx < 3'(RUN_MAX))
    `XTE_ASSERT_NEXT(a_accept_holds, i_clk, i_rst_n, i_in_valid && o_in_ready, w_status.hold_valid)
    `XTE_ASSERT_NOW(a_run_pending, i_clk, i_rst_n, o_out_valid && !o_last_of_run, w_status.hold_valid)

endmodule

// ===== tb/tb.sv =====
// Testbench for the XML text escaper unit: directed and random bytes checked by a scoreboard
`timescale 1ns / 1ps

import xte_pkg::*;

typedef struct {
    t_byte ch;
    logic  last;
} t_esc_char;

class escape_scoreboard;
    bit        codes_on;
    t_esc_char expected_q[$];
    int        errors;

    function string escape(t_byte b);
        string s;
        s = "";
        case (b)
            C_AMP:                    s = "&amp;";
            C_LT:                     s = "&lt;";
            C_QUOT:                   s = "&quot;";
            CODE_SKIP_A, CODE_SKIP_B: s = "";
            CODE_BOLD_ON:             if (codes_on) s = "<b>";
            CODE_BOLD_OFF:            if (codes_on) s = "</b>";
            CODE_NEWLINE:             if (codes_on) s = "<br/>";
            default: begin
                if (b >= HIGH_LOW)
                    s = $sformatf("&#%0d;", b);
                else if (b >= PRINT_LOW)
                    s = $sformatf("%c", b);
            end
        endcase
        return s;
    endfunction

    function void note_input(t_byte b);
        string     s;
        t_esc_char e;
        s = escape(b);
        for (int i = 0; i < s.len(); i++) begin
            e.ch   = s[i];
            e.last = (i == s.len() - 1);
            expected_q.push_back(e);
        end
    endfunction

    function void check_output(t_byte ch, logic last);
        t_esc_char e;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected output byte %h last %b", ch, last);
            return;
        end
        e = expected_q.pop_front();
        if (e.ch !== ch || e.last !== last) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected byte %h last %b, got byte %h last %b",
                         e.ch, e.last, ch, last);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 200000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    logic  i_cfg_control_codes_enable = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_byte i_in_byte = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_byte o_out_byte;
    logic  o_last_of_run;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    escape_scoreboard sb = new;

    xml_text_escaper_unit dut (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .i_cfg_valid                (i_cfg_valid),
        .o_cfg_ready                (o_cfg_ready),
        .i_cfg_control_codes_enable (i_cfg_control_codes_enable),
        .i_in_valid                 (i_in_valid),
        .o_in_ready                 (o_in_ready),
        .i_in_byte                  (i_in_byte),
        .o_out_valid                (o_out_valid),
        .i_out_ready                (i_out_ready),
        .o_out_byte                 (o_out_byte),
        .o_last_of_run              (o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off while hold_left runs down
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.codes_on = i_cfg_control_codes_enable;
            if (i_in_valid && o_in_ready)
                sb.note_input(i_in_byte);
            if (o_out_valid && i_out_ready)
                sb.check_output(o_out_byte, o_last_of_run);
        end
    end

    task automatic send_byte(input t_byte b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering and wait for every expected transfer, then wait further so a held dropped byte is retired
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic v);
        drain_outputs();
        i_cfg_valid                <= 1'b1;
        i_cfg_control_codes_enable <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_byte pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return t_byte'($urandom_range(127, 32));
        if (r < 45) begin
            case ($urandom_range(2))
                0:       return C_AMP;
                1:       return C_LT;
                default: return C_QUOT;
            endcase
        end
        if (r < 55) begin
            case ($urandom_range(4))
                0:       return CODE_SKIP_A;
                1:       return CODE_SKIP_B;
                2:       return CODE_BOLD_ON;
                3:       return CODE_BOLD_OFF;
                default: return CODE_NEWLINE;
            endcase
        end
        if (r < 65)
            return t_byte'($urandom_range(31, 0));
        return t_byte'($urandom_range(255, 128));
    endfunction

    // pressure: 1 = long receiver hold-off mid-phase, 2 = sender pause until drained
    task automatic run_phase(input int idle_pct, input int stall_pct, input int target,
                             input int pressure);
        int    sent;
        bit    pressed;
        t_byte b;
        sent           = 0;
        pressed        = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < target) begin
            b = pick_byte();
            send_byte(b);
            sent++;
            if (!pressed && sent >= target / 2) begin
                pressed = 1;
                if (pressure == 1)
                    hold_left <= 200;
                else if (pressure == 2)
                    drain_outputs();
            end
        end
    endtask

    initial begin
        t_byte directed_off[$];
        t_byte directed_on[$];
        directed_off = '{8'h00, 8'h1F, 8'h20, 8'h7F, 8'h80, 8'hFF, C_AMP, C_LT, C_QUOT,
                         C_GT, 8'hC8, CODE_SKIP_A, CODE_SKIP_B, CODE_BOLD_ON,
                         CODE_BOLD_OFF, CODE_NEWLINE};
        directed_on  = '{CODE_BOLD_ON, CODE_BOLD_OFF, CODE_NEWLINE, CODE_SKIP_A,
                         8'h64, 8'h99};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_off[i])
            send_byte(directed_off[i]);
        write_codes(1'b1);
        foreach (directed_on[i])
            send_byte(directed_on[i]);

        write_codes(1'b0);
        run_phase(0, 0, 77, 1);
        write_codes(1'b1);
        run_phase(49, 0, 77, 2);
        write_codes(1'b0);
        run_phase(0, 49, 77, 0);
        write_codes(1'b1);
        run_phase(17, 17, 77, 0);

        drain_outputs();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
